// ===== src/alr_pkg.sv =====
// shared constants and types for the linear resampler and framer
package alr_pkg;

	// sample and phase widths
	localparam int SAMPLE_W = 16;
	localparam int RAW_W    = 16;
	localparam int STEP_W   = 21;
	localparam int FRAC_W   = 16;
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int PROD_W   = DIFF_W + FRAC_W + 1;

	// phase step limits, 5.16 fixed point
	localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(1024);
	localparam logic [STEP_W-1:0] STEP_MAX   = STEP_W'(1048576);
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
	localparam logic [STEP_W-1:0] ONE_SAMPLE = STEP_W'(65536);

	// output framing
	localparam int FRAME_LENGTH = 160;
	localparam int FRAME_POS_W  = $clog2(FRAME_LENGTH + 1);

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = STEP_W;
	localparam logic [CFG_INDEX_W-1:0] CFG_STEP_RATE    = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_STEREO_MODE  = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] CFG_WIDE_SAMPLES = CFG_INDEX_W'(2);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [DIFF_W-1:0]   diff_t;
	typedef logic [RAW_W-1:0]           raw_t;

endpackage

// ===== src/alr_if.sv =====
// valid/ready channels for captured frames and resampled output
interface alr_frame_if;
	logic               valid;
	logic               ready;
	alr_pkg::raw_t      channel_a_raw;
	alr_pkg::raw_t      channel_b_raw;

	modport source (output valid, output channel_a_raw, output channel_b_raw, input ready);
	modport sink (input valid, input channel_a_raw, input channel_b_raw, output ready);
endinterface

interface alr_sample_if;
	logic               valid;
	logic               ready;
	alr_pkg::sample_t   out_sample;
	logic               frame_last;

	modport source (output valid, output out_sample, output frame_last, input ready);
	modport sink (input valid, input out_sample, input frame_last, output ready);
endinterface

// ===== src/audio_linear_resampler_framer.sv =====
// Linear-interpolation resampler with output framing. Each transfer on capture is one raw
// frame (8-bit unsigned or 16-bit signed, mono or stereo averaged); the block emits zero or
// more interpolated samples on resampled, one per step of a 5.16 phase accumulator, and
// flags every 160th output as the end of a frame. The very first frame after reset only
// primes the interpolator and leaves capture ready. Any later frame is accepted in S_IDLE,
// then each output takes a multiply (S_CHECK), a load (S_LOAD) and a transfer (S_WAIT,
// held while the output side stalls) of the single shared multiplier loop, and an exit
// check in S_CHECK returns to S_IDLE; capture is not ready during that time. Configuration
// writes on cfg_we take effect at the next captured frame.
module audio_linear_resampler_framer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [alr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [alr_pkg::CFG_DATA_W-1:0]    cfg_data,
	alr_frame_if.sink                         capture,
	alr_sample_if.source                      resampled
);

	typedef enum logic [1:0] {S_IDLE, S_CHECK, S_LOAD, S_WAIT} state_t;

	state_t                              state_q;
	logic [alr_pkg::STEP_W-1:0]          step_rate_q;
	logic                                stereo_mode_q;
	logic                                wide_samples_q;
	logic [alr_pkg::STEP_W-1:0]          step_q;
	logic [alr_pkg::STEP_W-1:0]          phase_q;
	logic [alr_pkg::FRAME_POS_W-1:0]     frame_pos_q;
	logic                                have_prev_q;
	alr_pkg::sample_t                    prev_q;
	alr_pkg::sample_t                    cur_q;
	alr_pkg::diff_t                      diff_q;
	logic                                out_valid_q;
	alr_pkg::sample_t                    out_sample_q;
	logic                                frame_last_q;

	alr_pkg::sample_t                    cur_sample;
	alr_pkg::sample_t                    interp_sample;
	logic [alr_pkg::STEP_W-1:0]          step_clamped;
	logic [alr_pkg::FRAME_POS_W:0]       frame_pos_next;
	logic                                mul_en;
	logic                                in_xfer;

	alr_convert u_convert (
		.channel_a_raw (capture.channel_a_raw),
		.channel_b_raw (capture.channel_b_raw),
		.stereo_mode   (stereo_mode_q),
		.wide_samples  (wide_samples_q),
		.sample        (cur_sample)
	);

	alr_interp u_interp (
		.clk    (clk),
		.mul_en (mul_en),
		.diff   (diff_q),
		.frac   (phase_q[alr_pkg::FRAC_W-1:0]),
		.prev   (prev_q),
		.sample (interp_sample)
	);

	// handshake and sequencer decodes
	assign capture.ready        = (state_q == S_IDLE);
	assign in_xfer              = capture.valid && (state_q == S_IDLE);
	assign mul_en               = (state_q == S_CHECK) && (phase_q < alr_pkg::ONE_SAMPLE);
	assign resampled.valid      = out_valid_q;
	assign resampled.out_sample = out_sample_q;
	assign resampled.frame_last = frame_last_q;

	// step limits
	always_comb begin
		if (step_rate_q < alr_pkg::STEP_MIN) begin
			step_clamped = alr_pkg::STEP_MIN;
		end else if (step_rate_q > alr_pkg::STEP_MAX) begin
			step_clamped = alr_pkg::STEP_MAX;
		end else begin
			step_clamped = step_rate_q;
		end
	end

	assign frame_pos_next = {1'b0, frame_pos_q} + (alr_pkg::FRAME_POS_W + 1)'(1);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_rate_q    <= alr_pkg::STEP_RESET;
			stereo_mode_q  <= 1'b0;
			wide_samples_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				alr_pkg::CFG_STEP_RATE:    step_rate_q    <= cfg_data;
				alr_pkg::CFG_STEREO_MODE:  stereo_mode_q  <= cfg_data[0];
				alr_pkg::CFG_WIDE_SAMPLES: wide_samples_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer, resampler state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= '0;
			frame_pos_q  <= '0;
			have_prev_q  <= 1'b0;
			prev_q       <= '0;
			out_valid_q  <= 1'b0;
			frame_last_q <= 1'b0;
			step_q       <= alr_pkg::STEP_RESET;
			cur_q        <= '0;
			diff_q       <= '0;
			out_sample_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						cur_q  <= cur_sample;
						step_q <= step_clamped;
						diff_q <= alr_pkg::DIFF_W'(cur_sample) - alr_pkg::DIFF_W'(prev_q);
						if (have_prev_q) begin
							state_q <= S_CHECK;
						end else begin
							prev_q      <= cur_sample;
							have_prev_q <= 1'b1;
						end
					end
				end
				S_CHECK: begin
					if (phase_q < alr_pkg::ONE_SAMPLE) begin
						state_q <= S_LOAD;
					end else begin
						phase_q <= phase_q - alr_pkg::ONE_SAMPLE;
						prev_q  <= cur_q;
						state_q <= S_IDLE;
					end
				end
				S_LOAD: begin
					out_sample_q <= interp_sample;
					out_valid_q  <= 1'b1;
					phase_q      <= phase_q + step_q;
					if (frame_pos_next >= (alr_pkg::FRAME_POS_W + 1)'(alr_pkg::FRAME_LENGTH)) begin
						frame_pos_q  <= '0;
						frame_last_q <= 1'b1;
					end else begin
						frame_pos_q  <= frame_pos_next[alr_pkg::FRAME_POS_W-1:0];
						frame_last_q <= 1'b0;
					end
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (resampled.ready) begin
						out_valid_q <= 1'b0;
						state_q     <= S_CHECK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/alr_convert.sv =====
// converts one raw capture frame into a signed 16-bit sample
module alr_convert (
	input  alr_pkg::raw_t    channel_a_raw,
	input  alr_pkg::raw_t    channel_b_raw,
	input  logic             stereo_mode,
	input  logic             wide_samples,
	output alr_pkg::sample_t sample
);

	alr_pkg::sample_t half_a;
	alr_pkg::sample_t half_b;
	logic [7:0]       byte_sum;
	logic [7:0]       byte_val;

	// floor halves of the 16-bit channels
	assign half_a = {channel_a_raw[15], channel_a_raw[15:1]};
	assign half_b = {channel_b_raw[15], channel_b_raw[15:1]};

	// byte average of truncated halves, offset 128 removed by flipping the top bit
	assign byte_sum = {1'b0, channel_a_raw[7:1]} + {1'b0, channel_b_raw[7:1]};
	assign byte_val = stereo_mode ? byte_sum : channel_a_raw[7:0];

	always_comb begin
		if (wide_samples) begin
			if (stereo_mode) begin
				sample = half_a + half_b;
			end else begin
				sample = channel_a_raw;
			end
		end else begin
			sample = {byte_val ^ 8'h80, 8'h00};
		end
	end

endmodule

// ===== src/alr_interp.sv =====
// shared multiply unit: registered diff * fraction, then floor shift and add
module alr_interp (
	input  logic                      clk,
	input  logic                      mul_en,
	input  alr_pkg::diff_t            diff,
	input  logic [alr_pkg::FRAC_W-1:0] frac,
	input  alr_pkg::sample_t          prev,
	output alr_pkg::sample_t          sample
);

	logic signed [alr_pkg::PROD_W-1:0]   product_q;
	logic signed [alr_pkg::DIFF_W:0]     offset;
	logic signed [alr_pkg::DIFF_W:0]     sum;

	// product register, loaded once per output
	always_ff @(posedge clk) begin
		if (mul_en) begin
			product_q <= diff * $signed({1'b0, frac});
		end
	end

	// arithmetic shift by 16 rounds toward minus infinity
	assign offset = product_q[alr_pkg::PROD_W-1 -: (alr_pkg::DIFF_W + 1)];
	assign sum    = {{2{prev[alr_pkg::SAMPLE_W-1]}}, prev} + offset;
	assign sample = sum[alr_pkg::SAMPLE_W-1:0];

endmodule

// ===== src/alr_checker.sv =====
// port-level checks for the resampler, bound to the top level
module alr_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input alr_pkg::sample_t out_sample,
	input logic             frame_last
);

	// a pending output holds until transferred
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped before transfer");

	// a stalled output keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_sample) && $stable(frame_last))
		else $error("output payload changed while stalled");

	// capture is closed while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("capture ready while output pending");

	// no output in the cycle after a capture transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("output valid right after capture transfer");

endmodule

bind audio_linear_resampler_framer alr_checker u_alr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (capture.valid),
	.in_ready   (capture.ready),
	.out_valid  (resampled.valid),
	.out_ready  (resampled.ready),
	.out_sample (resampled.out_sample),
	.frame_last (resampled.frame_last)
);
